// ----- rtl/att_pkg.sv -----
// Package for the ANSI text terminal: types, codes and constants.
// No dependencies.
`default_nettype none
package att_pkg;
    localparam logic [1:0] OP_PUT = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_SETCUR = 2'd2;
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam logic [7:0] CH_ESC = 8'h1b;
    localparam logic [7:0] CH_LBR = 8'h5b;
    localparam logic [7:0] CH_CR = 8'h0d;
    localparam logic [7:0] CH_LF = 8'h0a;
    localparam logic [7:0] CH_BS = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SEMI = 8'h3b;

    // CSI final bytes
    localparam logic [7:0] CH_SGR = 8'h6d;
    localparam logic [7:0] CH_UP = 8'h41;
    localparam logic [7:0] CH_DOWN = 8'h42;
    localparam logic [7:0] CH_RIGHT = 8'h43;
    localparam logic [7:0] CH_LEFT = 8'h44;
    localparam logic [7:0] CH_HOME = 8'h48;
    localparam logic [7:0] CH_CLEAR = 8'h4a;
    localparam logic [7:0] CH_ERASE = 8'h4b;
    localparam logic [7:0] CH_SAVE = 8'h73;
    localparam logic [7:0] CH_RESTORE = 8'h75;

    // SGR codes
    localparam logic [7:0] SGR_RESET = 8'd0;
    localparam logic [7:0] SGR_FG_LIGHT = 8'd1;
    localparam logic [7:0] SGR_BG_LIGHT = 8'd2;
    localparam logic [7:0] SGR_SWAP = 8'd7;
    localparam logic [7:0] SGR_HIDE = 8'd8;
    localparam logic [7:0] SGR_FG_LO = 8'd30;
    localparam logic [7:0] SGR_FG_HI = 8'd37;
    localparam logic [7:0] SGR_BG_LO = 8'd40;
    localparam logic [7:0] SGR_BG_HI = 8'd47;

    localparam logic [1:0] PM_PLAIN = 2'd0;
    localparam logic [1:0] PM_ESC = 2'd1;
    localparam logic [1:0] PM_CSI = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,   // post-reset fill sweep
        S_IDLE,
        S_RDWAIT,  // read cell, data next cycle
        S_GLYPH,   // write one glyph cell
        S_FILL,    // blank range sweep
        S_SCRRD,   // scroll: read source cell
        S_SCRWR,   // scroll: write one row up
        S_OUT,     // result waiting
        S_PLAIN    // byte held after a lone ESC, run as plain text
    } t_state;
endpackage
`default_nettype wire

// ----- rtl/att_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module att_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire                       i_clk,
    input  wire                       i_we,
    input  wire [$clog2(DEPTH)-1:0]   i_waddr,
    input  wire [WIDTH-1:0]           i_wdata,
    input  wire [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [WIDTH-1:0]          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/ansi_text_terminal.sv -----
// ANSI text terminal top level: parser, cursor, sequencer over the cell RAM.
// Depends on att_pkg and att_ram.
//
// channel | dir | fields
// s_axis  | in  | tdata: op[1:0] data_byte[9:2] col[16:10] row[21:17]
// m_axis  | out | tdata: cell_char[7:0] fg[11:8] bg[15:12] cur_col[22:16] cur_row[27:23]
//
// Tab writes spaces up to the next multiple of 4 columns, at most 4. ESC then a
// non-bracket byte writes the ESC glyph, then runs the byte as plain text. Scroll copies
// rows up one and blanks the last row; erase line blanks cursor to line end; clear screen
// blanks all cells and homes. After reset a clearing pass runs before the first beat.
// Output register holds the result until taken; input stalls meanwhile.
`default_nettype none
module ansi_text_terminal #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // op, data_byte, col, row
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata   // char, fg, bg, cursor_col, cursor_row
);
    import att_pkg::*;
    localparam int CELLS = COLS * ROWS;
    localparam int AW = $clog2(CELLS);
    localparam logic [6:0] LASTC = 7'(COLS - 1);
    localparam logic [4:0] LASTR = 5'(ROWS - 1);
    localparam logic [AW-1:0] LASTA = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROWSTEP = AW'(COLS);
    localparam logic [AW-1:0] LASTROWA = AW'(COLS * (ROWS - 1));

    t_state r_state, n_state;
    logic [6:0] r_col, n_col, r_scol, n_scol;
    logic [4:0] r_row, n_row, r_srow, n_srow;
    logic [3:0] r_fg, n_fg, r_bg, n_bg;
    logic [1:0] r_pm, n_pm;
    logic [7:0] r_pn, n_pn, r_pp, n_pp;
    logic [AW-1:0] r_addr, n_addr, r_end, n_end;
    logic [7:0] r_gch, n_gch;
    logic r_tab, n_tab, r_home, n_home;
    logic [15:0] r_cell, n_cell;
    logic r_ovalid, n_ovalid;
    logic r_pend, n_pend;
    logic [7:0] r_pbyte, n_pbyte;

    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0] wdata, rdata;

    att_ram #(.WIDTH(16), .DEPTH(CELLS)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    wire [1:0] in_op = s_axis_tdata[1:0];
    wire [7:0] in_b = s_axis_tdata[9:2];
    wire [6:0] in_c = s_axis_tdata[16:10];
    wire [4:0] in_r = s_axis_tdata[21:17];
    wire acc = s_axis_tvalid && s_axis_tready;
    wire [15:0] blank = {r_bg, r_fg, CH_SPACE};

    function automatic logic [AW-1:0] cell_addr(input logic [4:0] r, input logic [6:0] c);
        cell_addr = AW'(r * COLS) + AW'(c);
    endfunction

    // colour code on a fg/bg pair
    function automatic logic [7:0] colour(input logic [7:0] code, input logic [3:0] f,
                                           input logic [3:0] b);
        logic [3:0] nf, nb;
        nf = f; nb = b;
        case (code)
            SGR_RESET: nf = 4'd7;
            SGR_FG_LIGHT: nf = f | 4'd8;
            SGR_BG_LIGHT: nb = b | 4'd8;
            SGR_SWAP: begin nf = b; nb = f; end
            SGR_HIDE: begin nf = 4'd0; nb = 4'd0; end
            default: begin
                if (code inside {[SGR_FG_LO:SGR_FG_HI]}) nf = {f[3], code[2:0] - 3'd6};
                else if (code inside {[SGR_BG_LO:SGR_BG_HI]}) nb = {b[3], code[2:0]};
            end
        endcase
        colour = {nb, nf};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR; r_col <= '0; r_row <= '0; r_scol <= '0; r_srow <= '0;
            r_fg <= 4'd7; r_bg <= 4'd0; r_pm <= PM_PLAIN; r_pn <= '0; r_pp <= '0;
            r_addr <= '0; r_end <= LASTA; r_ovalid <= 1'b0; r_tab <= 1'b0;
            r_home <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_col <= n_col; r_row <= n_row; r_scol <= n_scol;
            r_srow <= n_srow; r_fg <= n_fg; r_bg <= n_bg; r_pm <= n_pm; r_pn <= n_pn;
            r_pp <= n_pp; r_addr <= n_addr; r_end <= n_end; r_ovalid <= n_ovalid;
            r_tab <= n_tab; r_home <= n_home; r_pend <= n_pend;
        end
        r_cell <= n_cell; r_gch <= n_gch; r_pbyte <= n_pbyte;
    end

    // next state
    always_comb begin
        logic [7:0] k;
        logic [7:0] v;
        logic [11:0] m;
        logic [7:0] cc;
        logic [6:0] nc;
        logic plain_go;
        logic [7:0] pb;
        n_state = r_state; n_col = r_col; n_row = r_row; n_scol = r_scol;
        n_srow = r_srow; n_fg = r_fg; n_bg = r_bg; n_pm = r_pm; n_pn = r_pn; n_pp = r_pp;
        n_addr = r_addr; n_end = r_end; n_cell = r_cell; n_gch = r_gch;
        n_ovalid = r_ovalid; n_tab = r_tab; n_home = r_home;
        n_pend = r_pend; n_pbyte = r_pbyte;
        k = (r_pn == 8'd0) ? 8'd1 : r_pn;
        m = 12'(r_pn) * 12'd10 + 12'(in_b - 8'h30);
        v = (m > 12'd255) ? 8'd255 : m[7:0];
        cc = '0; nc = '0;
        plain_go = 1'b0; pb = in_b;
        case (r_state)
            S_CLEAR, S_FILL: begin
                if (r_addr == r_end) begin
                    n_state = S_OUT; n_ovalid = 1'b1;
                    if (r_home) begin n_col = '0; n_row = '0; n_home = 1'b0; end
                end else n_addr = r_addr + AW'(1);
                if (r_state == S_CLEAR && r_addr == r_end) begin
                    n_state = S_IDLE; n_ovalid = 1'b0;
                end
            end
            S_IDLE: if (acc) begin
                n_cell = '0;
                n_state = S_OUT; n_ovalid = 1'b1;
                case (in_op)
                    OP_READ: begin
                        if (in_c <= LASTC && in_r <= LASTR) n_state = S_RDWAIT;
                        n_ovalid = (in_c <= LASTC && in_r <= LASTR) ? 1'b0 : 1'b1;
                    end
                    OP_SETCUR: begin
                        n_col = (in_c > LASTC) ? LASTC : in_c;
                        n_row = (in_r > LASTR) ? LASTR : in_r;
                    end
                    OP_PUT: begin
                        n_ovalid = 1'b0; n_state = S_GLYPH; n_tab = 1'b0;
                        if (r_pm == PM_ESC && in_b == CH_LBR) begin
                            n_pm = PM_CSI; n_pn = '0; n_pp = '0;
                            n_state = S_OUT; n_ovalid = 1'b1;
                        end else if (r_pm == PM_ESC) begin
                            // print the ESC glyph, then run this byte as plain text
                            n_gch = CH_ESC; n_pm = PM_PLAIN;
                            n_pend = 1'b1; n_pbyte = in_b;
                        end else if (r_pm == PM_CSI) begin
                            n_state = S_OUT; n_ovalid = 1'b1;
                            if (in_b inside {[8'h30:8'h39]}) n_pn = v;
                            else if (in_b == CH_SEMI) begin n_pp = r_pn; n_pn = '0; end
                            else begin
                                n_pm = PM_PLAIN;
                                case (in_b)
                                    CH_SGR: begin
                                        cc = (r_pp != 8'd0) ? colour(r_pp, r_fg, r_bg)
                                                            : {r_bg, r_fg};
                                        {n_bg, n_fg} = colour(r_pn, cc[3:0], cc[7:4]);
                                    end
                                    CH_UP: n_row = (8'(r_row) > k) ? r_row - k[4:0] : '0;
                                    CH_DOWN: n_row = (9'(r_row) + 9'(k) > 9'(LASTR)) ? LASTR
                                                    : r_row + k[4:0];
                                    CH_RIGHT: n_col = (9'(r_col) + 9'(k) > 9'(LASTC)) ? LASTC
                                                     : r_col + k[6:0];
                                    CH_LEFT: n_col = (8'(r_col) > k) ? r_col - k[6:0] : '0;
                                    CH_HOME: begin
                                        n_col = (r_pn > 8'(LASTC)) ? LASTC : r_pn[6:0];
                                        n_row = (r_pp > 8'(LASTR)) ? LASTR : r_pp[4:0];
                                    end
                                    CH_CLEAR: begin
                                        n_state = S_FILL; n_ovalid = 1'b0; n_addr = '0;
                                        n_end = LASTA; n_home = 1'b1;
                                    end
                                    CH_ERASE: begin
                                        n_state = S_FILL; n_ovalid = 1'b0;
                                        n_addr = cell_addr(r_row, r_col);
                                        n_end = cell_addr(r_row, LASTC);
                                    end
                                    CH_SAVE: begin n_scol = r_col; n_srow = r_row; end
                                    CH_RESTORE: begin n_col = r_scol; n_row = r_srow; end
                                    default: ;
                                endcase
                            end
                        end else plain_go = 1'b1;
                    end
                    default: ;
                endcase
            end
            S_RDWAIT: begin
                n_cell = rdata; n_state = S_OUT; n_ovalid = 1'b1;
            end
            S_GLYPH: begin
                // one glyph at cursor, then advance / wrap / scroll
                nc = r_col + 7'd1;
                n_state = S_OUT; n_ovalid = 1'b1;
                if (r_col == LASTC) begin
                    n_col = '0; n_tab = 1'b0;
                    if (r_row == LASTR) begin
                        n_state = S_SCRRD; n_ovalid = 1'b0; n_addr = ROWSTEP;
                    end else n_row = r_row + 5'd1;
                end else begin
                    n_col = nc;
                    if (r_tab && nc[1:0] != 2'd0) begin
                        n_state = S_GLYPH; n_ovalid = 1'b0;
                    end else n_tab = 1'b0;
                end
            end
            S_SCRRD: begin
                n_state = S_SCRWR;
            end
            S_SCRWR: begin
                if (r_addr == LASTA) begin
                    n_state = S_FILL; n_addr = LASTROWA; n_end = LASTA;
                end else begin
                    n_addr = r_addr + AW'(1); n_state = S_SCRRD;
                end
            end
            S_PLAIN: begin
                n_pend = 1'b0; plain_go = 1'b1; pb = r_pbyte;
            end
            S_OUT: if (m_axis_tready) begin
                n_ovalid = 1'b0; n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase

        // plain text byte, from the input or held after a lone ESC
        if (plain_go) begin
            n_state = S_OUT; n_ovalid = 1'b1;
            case (pb)
                CH_ESC: n_pm = PM_ESC;
                CH_CR: n_col = '0;
                CH_LF: begin
                    n_col = '0;
                    if (r_row == LASTR) begin
                        n_state = S_SCRRD; n_ovalid = 1'b0;
                        n_addr = ROWSTEP;
                    end else n_row = r_row + 5'd1;
                end
                CH_BS: begin
                    n_col = (r_col == 7'd0) ? LASTC : r_col - 7'd1;
                    n_state = S_FILL; n_ovalid = 1'b0;
                    n_addr = cell_addr(r_row, n_col); n_end = n_addr;
                end
                CH_TAB: begin
                    n_gch = CH_SPACE; n_tab = 1'b1;
                    n_state = S_GLYPH; n_ovalid = 1'b0;
                end
                default: begin
                    n_gch = pb; n_state = S_GLYPH; n_ovalid = 1'b0;
                end
            endcase
        end

        // ESC glyph done: the held byte runs before the result
        if (n_pend && n_state == S_OUT) begin
            n_state = S_PLAIN; n_ovalid = 1'b0;
        end
    end

    // memory port control
    always_comb begin
        we = 1'b0; waddr = r_addr; wdata = blank; raddr = r_addr;
        case (r_state)
            S_CLEAR, S_FILL: we = 1'b1;
            S_IDLE: raddr = cell_addr(in_r, in_c);
            S_GLYPH: begin
                we = 1'b1; waddr = cell_addr(r_row, r_col); wdata = {r_bg, r_fg, r_gch};
            end
            S_SCRWR: begin
                we = 1'b1; waddr = r_addr - ROWSTEP; wdata = rdata;
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {4'd0, r_row, r_col, r_cell};

    a_vld: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_ovalid && r_state != S_OUT))
        else $error("valid outside S_OUT");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && r_ovalid))
        else $error("ready while result held");
    a_row: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_row <= LASTR)
        else $error("row out of range");
    a_col: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_col <= LASTC)
        else $error("col out of range");
endmodule
`default_nettype wire
